// ===== rtl/core/iemp_pkg.sv =====
// iemp_pkg: shared widths, sequencer states and divider request/response types
// for the inverse-exponent / modular-power unit. No dependencies.

package iemp_pkg;

  // field width of base, key, order and results
  localparam int unsigned VW    = 16;
  // product / wide dividend width
  localparam int unsigned DW    = 2 * VW;
  // power modulus width (order + 1 may need one extra bit)
  localparam int unsigned MW    = VW + 1;
  // signed Euclid coefficient width
  localparam int unsigned CW    = VW + 2;
  // signed multiplier product width
  localparam int unsigned PW    = 2 * CW;
  // divider iteration counter width
  localparam int unsigned CNTW  = $clog2(DW + 1);

  // stream payload widths, padded to whole bytes
  localparam int unsigned S_TDATA_W = ((2 * VW + 7) / 8) * 8;
  localparam int unsigned M_TDATA_W = ((2 * VW + 7) / 8) * 8;

  // group order after reset
  localparam logic [VW-1:0] ORDER_RESET = VW'(1296);

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_EU_CHK,
    S_EU_DIV,
    S_EU_MUL,
    S_EU_UPD,
    S_LIFT,
    S_PW_BASE,
    S_PW_CHK,
    S_PW_DIV_A,
    S_PW_SQR,
    S_PW_DIV_S,
    S_OUT
  } state_e;

  // request to the shared divider
  typedef struct packed {
    logic          start;
    logic          wide;      // 1: full DW-bit dividend, 0: low VW bits only
    logic [DW-1:0] dividend;
    logic [MW-1:0] divisor;
  } div_req_t;

  // divider response
  typedef struct packed {
    logic          done;
    logic [DW-1:0] quot;
    logic [MW-1:0] rem;
  } div_rsp_t;

endpackage

// ===== rtl/core/inverse_exponent_then_modpow_unit.sv =====
// inverse_exponent_then_modpow_unit: top level of the inverse-exponent / modpow block.
// Depends on iemp_pkg and iemp_div.
//
// Usage:
//   A slave stream takes {exponent_key, base_value} in tdata, base in the low bits.
//   The key is inverted modulo the configured group order by the extended Euclidean
//   algorithm (negative coefficient lifted by the order), then the base is raised to
//   that inverse modulo order + 1 by square-and-multiply.
//   The master stream returns {power_result, inverse_key} in tdata and not_coprime
//   in tuser bit 0. One result per input transaction.
//   The user must write the group order through cfg_we_i / cfg_wdata_i only
//   while the block is idle; the block itself does not enforce this.
// Sequence: each Euclid step is a divide, a multiply and an update; then a
//   narrow divide reduces the base modulo order + 1, followed by a square for
//   each exponent bit below the top set bit and a multiply for each set bit,
//   each a wide pass of the shared divider. A zero key or zero inverse skips
//   the power stage.
// Throughput: one item at a time; tready is high only while the sequencer is idle.
// The finished result sits in an output register, so a new item is taken while a
// stalled result waits; a stalled receiver holds the result until tready.
// Reset clears the sequencer and the output valid and sets the order to 1296.

module inverse_exponent_then_modpow_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration: group order
  input  logic                             cfg_we_i,
  input  logic [iemp_pkg::VW-1:0]          cfg_wdata_i,
  // input stream
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [iemp_pkg::S_TDATA_W-1:0]   s_axis_tdata_i,   // base_value, exponent_key
  // result stream
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [iemp_pkg::M_TDATA_W-1:0]   m_axis_tdata_o,   // inverse_key, power_result
  output logic [0:0]                       m_axis_tuser_o    // not_coprime
);

  iemp_pkg::state_e state_q, state_d;

  logic [iemp_pkg::VW-1:0]        order_q;
  logic                           out_valid_q;
  logic [iemp_pkg::VW-1:0]        out_inv_q;
  logic [iemp_pkg::VW-1:0]        out_pow_q;
  logic                           out_ncp_q;

  // euclid registers
  logic [iemp_pkg::VW-1:0]        base_q;
  logic [iemp_pkg::VW-1:0]        rp_q;
  logic [iemp_pkg::VW-1:0]        r_q;
  logic [iemp_pkg::VW-1:0]        rn_q;
  logic [iemp_pkg::VW-1:0]        q_q;
  logic signed [iemp_pkg::CW-1:0] cp_q;
  logic signed [iemp_pkg::CW-1:0] c_q;
  logic signed [iemp_pkg::PW-1:0] prod_q;

  // power registers
  logic [iemp_pkg::VW-1:0]        inv_q;
  logic [iemp_pkg::VW-1:0]        exp_q;
  logic [iemp_pkg::VW-1:0]        acc_q;
  logic [iemp_pkg::VW-1:0]        sq_q;
  logic [iemp_pkg::MW-1:0]        mod_q;
  logic                           ncp_q;

  logic                           s_fire;
  logic                           out_free;
  logic signed [iemp_pkg::CW-1:0] lifted;
  logic [iemp_pkg::VW-1:0]        inv_w;
  logic [iemp_pkg::MW-1:0]        mod_w;
  logic signed [iemp_pkg::CW-1:0] mul_a;
  logic signed [iemp_pkg::CW-1:0] mul_b;
  logic signed [iemp_pkg::PW-1:0] mul_p;

  iemp_pkg::div_req_t div_req;
  iemp_pkg::div_rsp_t div_rsp;

  // shared divider
  iemp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign s_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;

  // lift a negative coefficient by the order, then the power modulus
  always_comb begin
    lifted = cp_q;
    if (cp_q < 0) begin
      lifted = cp_q + $signed({2'b00, order_q});
    end
    inv_w = lifted[iemp_pkg::VW-1:0];
    mod_w = {1'b0, order_q} + iemp_pkg::MW'(1);
  end

  // shared multiplier
  assign mul_p = mul_a * mul_b;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      iemp_pkg::S_IDLE: begin
        if (s_fire) state_d = iemp_pkg::S_EU_CHK;
      end
      iemp_pkg::S_EU_CHK: begin
        state_d = (r_q == '0) ? iemp_pkg::S_LIFT : iemp_pkg::S_EU_DIV;
      end
      iemp_pkg::S_EU_DIV: begin
        if (div_rsp.done) state_d = iemp_pkg::S_EU_MUL;
      end
      iemp_pkg::S_EU_MUL: begin
        state_d = iemp_pkg::S_EU_UPD;
      end
      iemp_pkg::S_EU_UPD: begin
        state_d = iemp_pkg::S_EU_CHK;
      end
      iemp_pkg::S_LIFT: begin
        state_d = (inv_w == '0) ? iemp_pkg::S_PW_CHK : iemp_pkg::S_PW_BASE;
      end
      iemp_pkg::S_PW_BASE: begin
        if (div_rsp.done) state_d = iemp_pkg::S_PW_CHK;
      end
      iemp_pkg::S_PW_CHK: begin
        if (exp_q == '0) begin
          state_d = iemp_pkg::S_OUT;
        end else if (exp_q[0]) begin
          state_d = iemp_pkg::S_PW_DIV_A;
        end else begin
          state_d = iemp_pkg::S_PW_SQR;
        end
      end
      iemp_pkg::S_PW_DIV_A: begin
        if (div_rsp.done) begin
          state_d = (exp_q[iemp_pkg::VW-1:1] == '0) ? iemp_pkg::S_PW_CHK : iemp_pkg::S_PW_SQR;
        end
      end
      iemp_pkg::S_PW_SQR: begin
        state_d = iemp_pkg::S_PW_DIV_S;
      end
      iemp_pkg::S_PW_DIV_S: begin
        if (div_rsp.done) state_d = iemp_pkg::S_PW_CHK;
      end
      iemp_pkg::S_OUT: begin
        if (out_free) state_d = iemp_pkg::S_IDLE;
      end
      default: begin
        state_d = iemp_pkg::S_IDLE;
      end
    endcase
  end

  // sequencer outputs: handshake, divider launch, multiplier operands
  always_comb begin
    s_axis_tready_o  = 1'b0;
    div_req.start    = 1'b0;
    div_req.wide     = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    mul_a            = '0;
    mul_b            = '0;
    case (state_q)
      iemp_pkg::S_IDLE: begin
        s_axis_tready_o = 1'b1;
      end
      iemp_pkg::S_EU_CHK: begin
        div_req.start    = (r_q != '0);
        div_req.dividend = iemp_pkg::DW'(rp_q);
        div_req.divisor  = {1'b0, r_q};
      end
      iemp_pkg::S_EU_MUL: begin
        mul_a = $signed({2'b00, q_q});
        mul_b = c_q;
      end
      iemp_pkg::S_LIFT: begin
        div_req.start    = (inv_w != '0);
        div_req.dividend = iemp_pkg::DW'(base_q);
        div_req.divisor  = mod_w;
      end
      iemp_pkg::S_PW_CHK: begin
        mul_a            = $signed({2'b00, acc_q});
        mul_b            = $signed({2'b00, sq_q});
        div_req.start    = (exp_q != '0) && exp_q[0];
        div_req.wide     = 1'b1;
        div_req.dividend = mul_p[iemp_pkg::DW-1:0];
        div_req.divisor  = mod_q;
      end
      iemp_pkg::S_PW_SQR: begin
        mul_a            = $signed({2'b00, sq_q});
        mul_b            = $signed({2'b00, sq_q});
        div_req.start    = 1'b1;
        div_req.wide     = 1'b1;
        div_req.dividend = mul_p[iemp_pkg::DW-1:0];
        div_req.divisor  = mod_q;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= iemp_pkg::S_IDLE;
      order_q     <= iemp_pkg::ORDER_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        order_q <= cfg_wdata_i;
      end
      if (state_q == iemp_pkg::S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      iemp_pkg::S_IDLE: begin
        if (s_fire) begin
          base_q <= s_axis_tdata_i[iemp_pkg::VW-1:0];
          r_q    <= s_axis_tdata_i[2*iemp_pkg::VW-1:iemp_pkg::VW];
          rp_q   <= order_q;
          cp_q   <= '0;
          c_q    <= iemp_pkg::CW'(1);
        end
      end
      iemp_pkg::S_EU_DIV: begin
        if (div_rsp.done) begin
          q_q  <= div_rsp.quot[iemp_pkg::VW-1:0];
          rn_q <= div_rsp.rem[iemp_pkg::VW-1:0];
        end
      end
      iemp_pkg::S_EU_MUL: begin
        prod_q <= mul_p;
      end
      iemp_pkg::S_EU_UPD: begin
        cp_q <= c_q;
        c_q  <= cp_q - prod_q[iemp_pkg::CW-1:0];
        rp_q <= r_q;
        r_q  <= rn_q;
      end
      iemp_pkg::S_LIFT: begin
        inv_q <= inv_w;
        exp_q <= inv_w;
        ncp_q <= (rp_q != iemp_pkg::VW'(1));
        mod_q <= mod_w;
        acc_q <= iemp_pkg::VW'(1);
      end
      iemp_pkg::S_PW_BASE: begin
        if (div_rsp.done) begin
          sq_q  <= div_rsp.rem[iemp_pkg::VW-1:0];
          acc_q <= (mod_q == iemp_pkg::MW'(1)) ? '0 : iemp_pkg::VW'(1);
        end
      end
      iemp_pkg::S_PW_DIV_A: begin
        if (div_rsp.done) begin
          acc_q <= div_rsp.rem[iemp_pkg::VW-1:0];
          // top bit done: no square needed
          if (exp_q[iemp_pkg::VW-1:1] == '0) begin
            exp_q <= exp_q >> 1;
          end
        end
      end
      iemp_pkg::S_PW_DIV_S: begin
        if (div_rsp.done) begin
          sq_q  <= div_rsp.rem[iemp_pkg::VW-1:0];
          exp_q <= exp_q >> 1;
        end
      end
      iemp_pkg::S_OUT: begin
        if (out_free) begin
          out_inv_q <= inv_q;
          out_pow_q <= acc_q;
          out_ncp_q <= ncp_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = iemp_pkg::M_TDATA_W'({out_pow_q, out_inv_q});
  assign m_axis_tuser_o  = out_ncp_q;

  // euclid remainder always shrinks below the divisor
  a_eu_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == iemp_pkg::S_EU_DIV && div_rsp.done) |->
      (div_rsp.rem[iemp_pkg::VW-1:0] < r_q))
    else $error("euclid remainder not below divisor");

  // the euclid loop only ends on a zero remainder
  a_lift_zero_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == iemp_pkg::S_LIFT) |-> (r_q == '0))
    else $error("euclid loop left with nonzero remainder");

  // reduced power operands stay below the modulus while bits remain
  a_pw_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == iemp_pkg::S_PW_CHK && exp_q != '0) |->
      ({1'b0, acc_q} < mod_q && {1'b0, sq_q} < mod_q))
    else $error("power operands not reduced");

  // a result only appears out of the result state
  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == iemp_pkg::S_OUT))
    else $error("result valid without result state");

endmodule

// ===== rtl/core/iemp_div.sv =====
// iemp_div: restoring radix-2 divider, one quotient bit per cycle.
// Depends on iemp_pkg for widths and the request/response structs.

module iemp_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  iemp_pkg::div_req_t req_i,
  output iemp_pkg::div_rsp_t rsp_o
);

  logic                        busy_q;
  logic                        done_q;
  logic [iemp_pkg::CNTW-1:0]   cnt_q;
  logic [iemp_pkg::DW-1:0]     quot_q;
  logic [iemp_pkg::MW-1:0]     rem_q;
  logic [iemp_pkg::MW-1:0]     dsr_q;

  logic [iemp_pkg::MW:0]       trial;
  logic [iemp_pkg::MW:0]       diff;
  logic                        ge;

  // one trial subtraction per cycle
  always_comb begin
    trial = {rem_q, quot_q[iemp_pkg::DW-1]};
    diff  = trial - {1'b0, dsr_q};
    ge    = (trial >= {1'b0, dsr_q});
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= req_i.wide ? iemp_pkg::CNTW'(iemp_pkg::DW) : iemp_pkg::CNTW'(iemp_pkg::VW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - iemp_pkg::CNTW'(1);
      if (cnt_q == iemp_pkg::CNTW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // datapath: narrow requests start with the dividend in the upper half
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quot_q <= req_i.wide ? req_i.dividend : (req_i.dividend << iemp_pkg::VW);
      rem_q  <= '0;
      dsr_q  <= req_i.divisor;
    end else if (busy_q) begin
      rem_q  <= ge ? diff[iemp_pkg::MW-1:0] : trial[iemp_pkg::MW-1:0];
      quot_q <= {quot_q[iemp_pkg::DW-2:0], ge};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;
  assign rsp_o.rem  = rem_q;

endmodule
